>>> src/kgfq_pkg.sv
// shared types, constants and helpers for the keyframe gated frame queue
// no dependencies; the design files refer to this package by scoped names
`timescale 1ns / 1ps

package kgfq_pkg;

    // queue geometry
    localparam int QUEUE_DEPTH = 64;
    localparam int IDX_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
    localparam int DROP_W      = CNT_W + 1;

    // configuration port
    localparam int ADDR_W = 3;
    localparam logic REG_CAPACITY    = 1'b0;
    localparam logic REG_MAX_PAYLOAD = 1'b1;
    localparam logic [6:0]  CAP_RESET = 7'd64;
    localparam logic [22:0] MAX_RESET = 23'd4194304;

    // item operation codes
    typedef enum logic [1:0] {
        MODE_PUSH = 2'd0,
        MODE_POP  = 2'd1,
        MODE_STOP = 2'd2
    } mode_t;

    // controller states
    typedef enum logic {
        ST_IDLE   = 1'b0,
        ST_FINISH = 1'b1
    } state_t;

    // commands from controller to datapath
    typedef struct packed {
        logic accept;
        logic finish;
    } cmd_t;

    // one result item
    typedef struct packed {
        logic        accepted;
        logic [6:0]  dropped_now;
        logic        request_keyframe;
        logic        oversize_error;
        logic        pop_valid;
        logic [31:0] pop_tag;
        logic [22:0] pop_length;
        logic [31:0] total_drops;
        logic [6:0]  queue_level;
        logic        waiting_for_keyframe;
    } result_t;

    // circular index advance
    function automatic logic [IDX_W-1:0] next_idx(input logic [IDX_W-1:0] i);
        logic [IDX_W-1:0] r;
        if (i == IDX_W'(QUEUE_DEPTH - 1)) begin
            r = '0;
        end
        else begin
            r = i + 1'b1;
        end
        return r;
    endfunction

    // low seven bits of a count, zero extended where the count is narrower
    function automatic logic [6:0] low7(input logic [DROP_W-1:0] v);
        logic [DROP_W+6:0] w;
        w = {7'b0, v};
        return w[6:0];
    endfunction

endpackage

>>> src/kgfq_ctrl.sv
// controller for the keyframe gated frame queue: accept / finish sequencing
// depends on kgfq_pkg
`timescale 1ns / 1ps

module kgfq_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  logic            buf_room,
    output kgfq_pkg::cmd_t  cmd
);

    kgfq_pkg::state_t state_reg;
    kgfq_pkg::state_t state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= kgfq_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        in_ready   = 1'b0;
        cmd        = '0;
        case (state_reg)
            kgfq_pkg::ST_IDLE:
            begin
                in_ready   = buf_room;
                cmd.accept = in_valid && buf_room;
                if (in_valid && buf_room)
                begin
                    state_next = kgfq_pkg::ST_FINISH;
                end
            end
            kgfq_pkg::ST_FINISH:
            begin
                cmd.finish = 1'b1;
                state_next = kgfq_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = kgfq_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

>>> src/kgfq_datapath.sv
// datapath: descriptor memories, queue pointers, drop policy, config registers
// depends on kgfq_pkg
`timescale 1ns / 1ps

module kgfq_datapath (
    input  logic                         clk,
    input  logic                         rst_n,
    input  kgfq_pkg::cmd_t               cmd,
    input  logic [1:0]                   mode,
    input  logic                         is_keyframe,
    input  logic [31:0]                  frame_tag,
    input  logic [23:0]                  payload_length,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [kgfq_pkg::ADDR_W-1:0]  paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output kgfq_pkg::result_t            res
);

    // descriptor memories
    logic [31:0] tag_mem [kgfq_pkg::QUEUE_DEPTH];
    logic [22:0] len_mem [kgfq_pkg::QUEUE_DEPTH];
    logic [31:0] rd_tag_reg;
    logic [22:0] rd_len_reg;

    // queue state
    logic [kgfq_pkg::IDX_W-1:0] head_reg, head_next;
    logic [kgfq_pkg::IDX_W-1:0] tail_reg, tail_next;
    logic [kgfq_pkg::CNT_W-1:0] fill_reg, fill_next;
    logic                       await_reg, await_next;
    logic                       halted_reg, halted_next;
    logic [31:0]                total_reg, total_next;

    // config registers
    logic [6:0]  cap_reg;
    logic [22:0] max_reg;

    // per-item work
    kgfq_pkg::result_t           pend_reg, pend_next;
    logic                        mem_we;
    logic [kgfq_pkg::IDX_W-1:0]  wr_idx;
    logic [kgfq_pkg::DROP_W-1:0] drop;
    logic [32:0]                 drop_sum;
    logic [31:0]                 eff_cap;
    logic                        full;
    logic                        oversize;

    // apb register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg <= kgfq_pkg::CAP_RESET;
            max_reg <= kgfq_pkg::MAX_RESET;
        end
        else if (psel && penable && pwrite)
        begin
            case (paddr[2])
                kgfq_pkg::REG_CAPACITY:    cap_reg <= pwdata[6:0];
                kgfq_pkg::REG_MAX_PAYLOAD: max_reg <= pwdata[22:0];
                default: ;
            endcase
        end
    end

    // apb register reads
    always_comb
    begin
        case (paddr[2])
            kgfq_pkg::REG_CAPACITY:    prdata = {25'b0, cap_reg};
            kgfq_pkg::REG_MAX_PAYLOAD: prdata = {9'b0, max_reg};
            default:                   prdata = '0;
        endcase
    end

    // capacity clamp and checks
    always_comb
    begin
        if (cap_reg == 7'd0)
        begin
            eff_cap = 32'd1;
        end
        else if (32'(cap_reg) > 32'(kgfq_pkg::QUEUE_DEPTH))
        begin
            eff_cap = 32'(kgfq_pkg::QUEUE_DEPTH);
        end
        else
        begin
            eff_cap = 32'(cap_reg);
        end
        full     = 32'(fill_reg) >= eff_cap;
        oversize = payload_length > {1'b0, max_reg};
    end

    // drop policy and queue update for the accepted item
    always_comb
    begin
        head_next   = head_reg;
        tail_next   = tail_reg;
        fill_next   = fill_reg;
        await_next  = await_reg;
        halted_next = halted_reg;
        mem_we      = 1'b0;
        wr_idx      = tail_reg;
        drop        = '0;
        pend_next   = '0;
        case (kgfq_pkg::mode_t'(mode))
            kgfq_pkg::MODE_PUSH:
            begin
                if (!halted_reg)
                begin
                    if (oversize)
                    begin
                        drop                       = kgfq_pkg::DROP_W'(1);
                        pend_next.request_keyframe = 1'b1;
                        pend_next.oversize_error   = 1'b1;
                    end
                    else if (await_reg && !is_keyframe)
                    begin
                        drop = kgfq_pkg::DROP_W'(1);
                    end
                    else if (is_keyframe)
                    begin
                        // keyframe: flush and store at slot zero
                        await_next         = 1'b0;
                        drop               = kgfq_pkg::DROP_W'(fill_reg);
                        mem_we             = 1'b1;
                        wr_idx             = '0;
                        head_next          = '0;
                        tail_next          = kgfq_pkg::next_idx('0);
                        fill_next          = kgfq_pkg::CNT_W'(1);
                        pend_next.accepted = 1'b1;
                    end
                    else if (full)
                    begin
                        // overflow: flush, drop incoming, resync on keyframe
                        drop                       = kgfq_pkg::DROP_W'(fill_reg)
                                                     + kgfq_pkg::DROP_W'(1);
                        head_next                  = '0;
                        tail_next                  = '0;
                        fill_next                  = '0;
                        await_next                 = 1'b1;
                        pend_next.request_keyframe = 1'b1;
                    end
                    else
                    begin
                        mem_we             = 1'b1;
                        tail_next          = kgfq_pkg::next_idx(tail_reg);
                        fill_next          = fill_reg + 1'b1;
                        pend_next.accepted = 1'b1;
                    end
                end
            end
            kgfq_pkg::MODE_POP:
            begin
                if (fill_reg != '0)
                begin
                    pend_next.pop_valid = 1'b1;
                    head_next           = kgfq_pkg::next_idx(head_reg);
                    fill_next           = fill_reg - 1'b1;
                end
            end
            kgfq_pkg::MODE_STOP:
            begin
                halted_next = 1'b1;
                head_next   = '0;
                tail_next   = '0;
                fill_next   = '0;
            end
            default: ;
        endcase

        // saturating drop total
        drop_sum = {1'b0, total_reg} + {{(33 - kgfq_pkg::DROP_W){1'b0}}, drop};
        total_next = drop_sum[32] ? 32'hFFFF_FFFF : drop_sum[31:0];

        pend_next.dropped_now          = kgfq_pkg::low7(drop);
        pend_next.total_drops          = total_next;
        pend_next.queue_level          = kgfq_pkg::low7(kgfq_pkg::DROP_W'(fill_next));
        pend_next.waiting_for_keyframe = await_next;
    end

    // control state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg   <= '0;
            tail_reg   <= '0;
            fill_reg   <= '0;
            await_reg  <= 1'b0;
            halted_reg <= 1'b0;
            total_reg  <= '0;
        end
        else if (cmd.accept)
        begin
            head_reg   <= head_next;
            tail_reg   <= tail_next;
            fill_reg   <= fill_next;
            await_reg  <= await_next;
            halted_reg <= halted_next;
            total_reg  <= total_next;
        end
    end

    // descriptor memory write and head read
    always_ff @(posedge clk)
    begin
        if (cmd.accept && mem_we)
        begin
            tag_mem[wr_idx] <= frame_tag;
            len_mem[wr_idx] <= payload_length[22:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            rd_tag_reg <= tag_mem[head_reg];
            rd_len_reg <= len_mem[head_reg];
            pend_reg   <= pend_next;
        end
    end

    // result assembly in the finish cycle
    always_comb
    begin
        res = pend_reg;
        if (pend_reg.pop_valid)
        begin
            res.pop_tag    = rd_tag_reg;
            res.pop_length = rd_len_reg;
        end
    end

endmodule

>>> src/kgfq_out_buf.sv
// two-entry result buffer between the datapath and the output channel
// depends on kgfq_pkg
`timescale 1ns / 1ps

module kgfq_out_buf (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               wr_en,
    input  kgfq_pkg::result_t  wr_data,
    output logic               room,
    output logic               out_valid,
    input  logic               out_ready,
    output kgfq_pkg::result_t  rd_data
);

    kgfq_pkg::result_t slot_reg [2];
    logic              wr_ptr_reg, wr_ptr_next;
    logic              rd_ptr_reg, rd_ptr_next;
    logic [1:0]        count_reg, count_next;
    logic              rd_en;

    assign out_valid = count_reg != 2'd0;
    assign room      = count_reg != 2'd2;
    assign rd_en     = out_valid && out_ready;
    assign rd_data   = slot_reg[rd_ptr_reg];

    // pointer and count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ wr_en;
        rd_ptr_next = rd_ptr_reg ^ rd_en;
        count_next  = count_reg + {1'b0, wr_en} - {1'b0, rd_en};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // result storage
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            slot_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

>>> src/keyframe_gated_frame_queue.sv
// top level of the keyframe gated frame queue
// depends on kgfq_pkg, kgfq_ctrl, kgfq_datapath, kgfq_out_buf
`timescale 1ns / 1ps

// usage
// - input channel (in_valid / in_ready): one item per transfer, mode selects
//   push of a frame descriptor, pop of the oldest descriptor, or stop
// - output channel (out_valid / out_ready): exactly one result per item
// - apb port: capacity at byte address 0, max payload length at address 4;
//   write only while no item is in flight
// - each item passes an idle step, which applies the drop policy and reads
//   the head entry of the descriptor memory, then a finish step, which
//   forms the result and writes it into the result buffer; in_ready is low
//   in the finish step, so a new item is taken only after the last is done
// - the descriptor memory has one write and one registered read port; the
//   registered head read is why the result is formed in the finish step
// - a two-entry result buffer lets a new item be taken while one result
//   still waits; when both entries are full in_ready drops until the
//   receiver takes a result
// - reset empties the queue, clears waiting and halted state and the drop
//   total, and restores both registers; memory contents are not cleared
//   since only entries that hold a descriptor are ever returned
module keyframe_gated_frame_queue (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [1:0]                   mode,
    input  logic                         is_keyframe,
    input  logic [31:0]                  frame_tag,
    input  logic [23:0]                  payload_length,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic                         accepted,
    output logic [6:0]                   dropped_now,
    output logic                         request_keyframe,
    output logic                         oversize_error,
    output logic                         pop_valid,
    output logic [31:0]                  pop_tag,
    output logic [22:0]                  pop_length,
    output logic [31:0]                  total_drops,
    output logic [6:0]                   queue_level,
    output logic                         waiting_for_keyframe,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [kgfq_pkg::ADDR_W-1:0]  paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready
);

    kgfq_pkg::cmd_t    cmd;
    kgfq_pkg::result_t res;
    kgfq_pkg::result_t out_res;
    logic              buf_room;

    assign pready = 1'b1;

    kgfq_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .buf_room (buf_room),
        .cmd      (cmd)
    );

    kgfq_datapath u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .mode           (mode),
        .is_keyframe    (is_keyframe),
        .frame_tag      (frame_tag),
        .payload_length (payload_length),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .res            (res)
    );

    kgfq_out_buf u_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .wr_en     (cmd.finish),
        .wr_data   (res),
        .room      (buf_room),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .rd_data   (out_res)
    );

    // result fields to ports
    assign accepted             = out_res.accepted;
    assign dropped_now          = out_res.dropped_now;
    assign request_keyframe     = out_res.request_keyframe;
    assign oversize_error       = out_res.oversize_error;
    assign pop_valid            = out_res.pop_valid;
    assign pop_tag              = out_res.pop_tag;
    assign pop_length           = out_res.pop_length;
    assign total_drops          = out_res.total_drops;
    assign queue_level          = out_res.queue_level;
    assign waiting_for_keyframe = out_res.waiting_for_keyframe;

endmodule

>>> src/kgfq_checker.sv
// port-level checks for the keyframe gated frame queue, bound to the top level
// depends on keyframe_gated_frame_queue
`timescale 1ns / 1ps

module kgfq_assert (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         out_valid,
    input logic                         out_ready,
    input logic                         accepted,
    input logic [6:0]                   dropped_now,
    input logic                         request_keyframe,
    input logic                         oversize_error,
    input logic                         pop_valid,
    input logic [31:0]                  pop_tag,
    input logic [22:0]                  pop_length
);

    // a stalled result stays offered
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result withdrawn before transfer");

    // a result is never both a stored push and a pop
    a_push_pop_excl: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(accepted && pop_valid))
        else $error("push and pop reported in one result");

    // an oversize frame is a single drop with a keyframe request
    a_oversize: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && oversize_error |->
            request_keyframe && !accepted && dropped_now == 7'd1)
        else $error("oversize result inconsistent");

    // an empty pop carries no descriptor
    a_pop_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !pop_valid |-> pop_tag == 32'd0 && pop_length == 23'd0)
        else $error("descriptor data without a popped frame");

endmodule

bind keyframe_gated_frame_queue kgfq_assert u_kgfq_assert (
    .clk              (clk),
    .rst_n            (rst_n),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .accepted         (accepted),
    .dropped_now      (dropped_now),
    .request_keyframe (request_keyframe),
    .oversize_error   (oversize_error),
    .pop_valid        (pop_valid),
    .pop_tag          (pop_tag),
    .pop_length       (pop_length)
);
